[rtl/core/bssc_pkg.sv]
package bssc_pkg;

   // Field widths
   localparam int OPCODE_W   = 2;
   localparam int SECTOR_W   = 3;
   localparam int MODE_W     = 1;
   localparam int SPEED_W    = 8;
   localparam int PWM_W      = 15;
   localparam int DUTY_W     = 15;
   localparam int STEP_W     = 14;
   localparam int DELAY_W    = 16;

   // Stream and config port widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   // Timing constants
   localparam int STEP_PRESCALE = 8;
   localparam int PRESCALE_W    = $clog2(STEP_PRESCALE) > 0 ? $clog2(STEP_PRESCALE) : 1;
   localparam int STEP_BASE     = 13035;
   localparam int DELAY_BASE    = (1842500 / 1059) * 20;
   localparam int DUTY_DIVISOR  = 255;

   // Serial divider: dividend wide enough for both timer bases
   localparam int DIV_W     = DELAY_W;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);
   localparam int SECTOR_LAST = 5;

   // duty = (pwm_period * speed * DUTY_RECIP) >> DUTY_SHIFT, exact for 23-bit products
   localparam int DUTY_PROD_W  = PWM_W + SPEED_W;
   localparam int DUTY_RECIP   = 8421505;
   localparam int DUTY_RECIP_W = 24;
   localparam int DUTY_SHIFT   = 31;
   localparam int DUTY_MUL_W   = DUTY_PROD_W + DUTY_RECIP_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE_SEL   = 2'd0,
      CSR_SPEED      = 2'd1,
      CSR_PWM_PERIOD = 2'd2
   } csr_index_type;

   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK   = 2'd0,
      OP_EDGE_A = 2'd1,
      OP_EDGE_B = 2'd2,
      OP_EDGE_C = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      DIV_SEL_STEP  = 2'd0,
      DIV_SEL_DELAY = 2'd1
   } div_sel_type;

   typedef enum logic [2:0] {
      ST_RUN,
      ST_START_STEP,
      ST_WAIT_STEP,
      ST_START_DELAY,
      ST_WAIT_DELAY
   } state_type;

   typedef struct packed {
      logic        item_en;
      logic        div_start;
      div_sel_type div_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
   } dp_status_type;

endpackage

[rtl/core/bldc_six_step_commutator.sv]
// Six-step brushless motor commutation controller.
// req_ channel: one beat per event, either a clock tick or a phase
//   zero-crossing edge with its comparator level.
// rsp_ channel: one beat per request beat carrying the sector to apply, a
//   commutate strobe, the drive enable and the PWM duty.
// csr_ port: single-cycle register writes (mode, speed, PWM period).
// A result is registered, valid the cycle after its request beat is taken.
// Throughput: one beat per cycle while no recompute runs and the result
//   register drains or is empty; a stalled rsp_tready holds the result and
//   back-pressures req_. Every csr write starts a recompute of the step and
//   delay periods on a shared bit-serial divider in two passes, so req_tready
//   stays low until both are done; duty is scaled by a constant reciprocal
//   in two register stages meanwhile.
// Reset clears the registers (speed zero, drive off), the sector, the
//   timers and the result valid flag; the block is ready right away.
module bldc_six_step_commutator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [bssc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bssc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [1:0] opcode, [2] level, [7:3] zero
   input  logic [bssc_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [2:0] sector_out, [3] commutate, [4] drive_on, [19:5] duty, [23:20] zero
   output logic [bssc_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import bssc_pkg::*;

   dp_cmd_type          cmd;
   dp_status_type       status;
   logic [SECTOR_W-1:0] sector_out;
   logic                commutate;
   logic                drive_on;
   logic [DUTY_W-1:0]   duty;

   bssc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   bssc_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .opcode     (req_tdata[OPCODE_W-1:0]),
      .level      (req_tdata[OPCODE_W]),
      .cmd        (cmd),
      .status     (status),
      .sector_out (sector_out),
      .commutate  (commutate),
      .drive_on   (drive_on),
      .duty       (duty)
   );

   assign rsp_tdata = {(RSP_DATA_W-SECTOR_W-2-DUTY_W)'(0), duty, drive_on, commutate,
                       sector_out};

endmodule

[rtl/core/bssc_ctrl.sv]
module bssc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output bssc_pkg::dp_cmd_type   cmd,
   input  bssc_pkg::dp_status_type status
);
   import bssc_pkg::*;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_RUN) && (!out_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;

   always_comb begin
      if (accept)
         out_valid_in = 1'b1;
      else if (rsp_tready)
         out_valid_in = 1'b0;
      else
         out_valid_in = out_valid_ff;
   end

   always_comb begin
      state_in      = state_ff;
      cmd.item_en   = accept;
      cmd.div_start = 1'b0;
      cmd.div_sel   = DIV_SEL_STEP;
      case (state_ff)
         ST_RUN: begin
         end
         ST_START_STEP: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SEL_STEP;
            state_in      = ST_WAIT_STEP;
         end
         ST_WAIT_STEP: begin
            if (status.div_done) state_in = ST_START_DELAY;
         end
         ST_START_DELAY: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SEL_DELAY;
            state_in      = ST_WAIT_DELAY;
         end
         ST_WAIT_DELAY: begin
            if (status.div_done) state_in = ST_RUN;
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
      // new settings restart the whole recompute sequence
      if (csr_we) begin
         state_in      = ST_START_STEP;
         cmd.div_start = 1'b0;
      end
   end

endmodule

[rtl/core/bssc_dp.sv]
module bssc_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [bssc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bssc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [bssc_pkg::OPCODE_W-1:0]        opcode,
   input  logic                                 level,
   input  bssc_pkg::dp_cmd_type                 cmd,
   output bssc_pkg::dp_status_type              status,
   output logic [bssc_pkg::SECTOR_W-1:0]        sector_out,
   output logic                                 commutate,
   output logic                                 drive_on,
   output logic [bssc_pkg::DUTY_W-1:0]          duty
);
   import bssc_pkg::*;

   // Configuration
   logic [MODE_W-1:0]  mode_sel_ff;
   logic [SPEED_W-1:0] speed_ff;
   logic [PWM_W-1:0]   pwm_period_ff;

   // Precomputed quotients
   logic [STEP_W-1:0]  step_period_ff;
   logic [DELAY_W-1:0] delay_period_ff;
   logic [DUTY_W-1:0]  duty_q_ff;

   // Duty scaling
   logic [DUTY_PROD_W-1:0] product_ff;
   logic [DUTY_MUL_W-1:0]  duty_mul;

   // Serial divider
   logic [DIV_W-1:0]     dvd_ff, dvd_in;
   logic [SPEED_W-1:0]   rem_ff, rem_in;
   logic [SPEED_W-1:0]   divisor_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   div_sel_type          sel_ff;
   logic [SPEED_W:0]     rem_sh;
   logic [SPEED_W:0]     rem_diff;
   logic                 q_bit;
   logic [DIV_W-1:0]     dividend;
   logic [SPEED_W-1:0]   divisor;

   // Commutation state
   logic [SECTOR_W-1:0]   sector_ff, sector_in;
   logic [PRESCALE_W-1:0] prescale_ff, prescale_in;
   logic [STEP_W-1:0]     step_cnt_ff, step_cnt_in;
   logic [DELAY_W-1:0]    delay_cnt_ff, delay_cnt_in;

   // Result register
   logic [SECTOR_W-1:0] sector_out_ff, sector_out_in;
   logic                commutate_ff, commutate_in;
   logic                drive_on_ff, drive_on_in;
   logic [DUTY_W-1:0]   duty_ff, duty_in;

   logic [PRESCALE_W:0] pre_inc;
   logic [STEP_W:0]     step_inc;
   logic [DELAY_W:0]    delay_inc;
   logic [SECTOR_W-1:0] edge_sector;
   logic                edge_fit;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_sel_ff   <= '0;
         speed_ff      <= '0;
         pwm_period_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE_SEL:   mode_sel_ff   <= csr_wdata[MODE_W-1:0];
            CSR_SPEED:      speed_ff      <= csr_wdata[SPEED_W-1:0];
            CSR_PWM_PERIOD: pwm_period_ff <= csr_wdata[PWM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------- duty ----------------
   // divide by 255 as a reciprocal multiply, registered in product_ff then duty_q_ff
   assign duty_mul = DUTY_MUL_W'(product_ff) * DUTY_MUL_W'(DUTY_RECIP);

   always_ff @(posedge clock) begin
      product_ff <= DUTY_PROD_W'(pwm_period_ff) * DUTY_PROD_W'(speed_ff);
      duty_q_ff  <= duty_mul[DUTY_SHIFT +: DUTY_W];
   end

   // ---------------- divider ----------------
   always_comb begin
      case (cmd.div_sel)
         DIV_SEL_STEP: begin
            dividend = DIV_W'(STEP_BASE);
            divisor  = speed_ff;
         end
         DIV_SEL_DELAY: begin
            dividend = DIV_W'(DELAY_BASE);
            divisor  = speed_ff;
         end
         default: begin
            dividend = '0;
            divisor  = speed_ff;
         end
      endcase
   end

   assign rem_sh   = {rem_ff, dvd_ff[DIV_W-1]};
   assign rem_diff = rem_sh - {1'b0, divisor_ff};
   assign q_bit    = (rem_sh >= {1'b0, divisor_ff});
   assign rem_in   = q_bit ? rem_diff[SPEED_W-1:0] : rem_sh[SPEED_W-1:0];
   assign dvd_in   = {dvd_ff[DIV_W-2:0], q_bit};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (cmd.div_start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= DIV_CNT_W'(DIV_W);
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff - 1'b1;
         busy_ff <= (cnt_ff != DIV_CNT_W'(1));
         done_ff <= (cnt_ff == DIV_CNT_W'(1));
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dvd_ff     <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
         sel_ff     <= cmd.div_sel;
      end else if (busy_ff) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done_ff) begin
         case (sel_ff)
            DIV_SEL_STEP:  step_period_ff  <= dvd_ff[STEP_W-1:0];
            DIV_SEL_DELAY: delay_period_ff <= dvd_ff[DELAY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign status.div_done = done_ff;

   // ---------------- commutation ----------------
   // zero-crossing edges that fit the present sector
   always_comb begin
      edge_fit    = 1'b0;
      edge_sector = sector_ff;
      case (opcode)
         OP_EDGE_A: begin
            if (!level && sector_ff == 3'd2) begin
               edge_fit = 1'b1; edge_sector = 3'd3;
            end else if (level && sector_ff == 3'd5) begin
               edge_fit = 1'b1; edge_sector = 3'd0;
            end
         end
         OP_EDGE_B: begin
            if (!level && sector_ff == 3'd4) begin
               edge_fit = 1'b1; edge_sector = 3'd5;
            end else if (level && sector_ff == 3'd1) begin
               edge_fit = 1'b1; edge_sector = 3'd2;
            end
         end
         OP_EDGE_C: begin
            if (!level && sector_ff == 3'd0) begin
               edge_fit = 1'b1; edge_sector = 3'd1;
            end else if (level && sector_ff == 3'd3) begin
               edge_fit = 1'b1; edge_sector = 3'd4;
            end
         end
         default: begin
         end
      endcase
   end

   assign pre_inc   = {1'b0, prescale_ff} + 1'b1;
   assign step_inc  = {1'b0, step_cnt_ff} + 1'b1;
   assign delay_inc = {1'b0, delay_cnt_ff} + 1'b1;

   always_comb begin
      sector_in     = sector_ff;
      prescale_in   = prescale_ff;
      step_cnt_in   = step_cnt_ff;
      delay_cnt_in  = delay_cnt_ff;
      sector_out_in = sector_ff;
      commutate_in  = 1'b0;
      drive_on_in   = 1'b0;
      duty_in       = '0;
      if (speed_ff == '0) begin
         prescale_in  = '0;
         step_cnt_in  = '0;
         delay_cnt_in = '0;
      end else begin
         drive_on_in = 1'b1;
         duty_in     = duty_q_ff;
         if (mode_sel_ff == '0) begin
            if (opcode == OP_TICK) begin
               if (pre_inc >= (PRESCALE_W+1)'(STEP_PRESCALE)) begin
                  prescale_in = '0;
                  if (step_inc >= {1'b0, step_period_ff}) begin
                     step_cnt_in  = '0;
                     commutate_in = 1'b1;
                     sector_in    = (sector_ff >= SECTOR_W'(SECTOR_LAST)) ?
                                    '0 : sector_ff + 1'b1;
                  end else begin
                     step_cnt_in = step_inc[STEP_W-1:0];
                  end
               end else begin
                  prescale_in = pre_inc[PRESCALE_W-1:0];
               end
            end
         end else begin
            if (opcode == OP_TICK) begin
               if (delay_inc >= {1'b0, delay_period_ff}) begin
                  delay_cnt_in = '0;
                  commutate_in = 1'b1;
               end else begin
                  delay_cnt_in = delay_inc[DELAY_W-1:0];
               end
            end else if (edge_fit) begin
               sector_in     = edge_sector;
               delay_cnt_in  = '0;
               sector_out_in = edge_sector;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_ff    <= '0;
         prescale_ff  <= '0;
         step_cnt_ff  <= '0;
         delay_cnt_ff <= '0;
      end else if (cmd.item_en) begin
         sector_ff    <= sector_in;
         prescale_ff  <= prescale_in;
         step_cnt_ff  <= step_cnt_in;
         delay_cnt_ff <= delay_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.item_en) begin
         sector_out_ff <= sector_out_in;
         commutate_ff  <= commutate_in;
         drive_on_ff   <= drive_on_in;
         duty_ff       <= duty_in;
      end
   end

   assign sector_out = sector_out_ff;
   assign commutate  = commutate_ff;
   assign drive_on   = drive_on_ff;
   assign duty       = duty_ff;

endmodule

[test/bldc_six_step_commutator_checker.sv]
module bldc_six_step_commutator_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [bssc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bssc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   // [1:0] opcode, [2] level, [7:3] zero
   input  logic [bssc_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [2:0] sector_out, [3] commutate, [4] drive_on, [19:5] duty, [23:20] zero
   input  logic [bssc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output int                                pending,
   output int                                fail_count,
   output int                                checked_count,
   output int                                commutation_count
);
   import bssc_pkg::*;

   typedef struct packed {
      logic [DUTY_W-1:0]   duty;
      logic                drive_on;
      logic                commutate;
      logic [SECTOR_W-1:0] sector;
   } bridge_cmd_type;

   localparam logic [SECTOR_W-1:0] NO_FIT = '1;

   bridge_cmd_type expected_cmds [$];

   logic                  mode_q;
   logic [SPEED_W-1:0]    speed_q;
   logic [PWM_W-1:0]      pwm_q;
   logic [SECTOR_W-1:0]   sector_q;
   logic [PRESCALE_W-1:0] prescale_q;
   logic [STEP_W-1:0]     step_q;
   logic [DELAY_W-1:0]    delay_q;

   // Each sector accepts exactly one phase/direction; the edge moves it one sector on.
   function automatic logic [SECTOR_W-1:0] fitting_sector(input opcode_type op,
                                                          input logic lvl,
                                                          input logic [SECTOR_W-1:0] s);
      logic [SECTOR_W-1:0] target;
      target = NO_FIT;
      case (op)
         OP_EDGE_A: begin
            if (!lvl && s == 3'd2) target = 3'd3;
            else if (lvl && s == 3'd5) target = 3'd0;
         end
         OP_EDGE_B: begin
            if (!lvl && s == 3'd4) target = 3'd5;
            else if (lvl && s == 3'd1) target = 3'd2;
         end
         OP_EDGE_C: begin
            if (!lvl && s == 3'd0) target = 3'd1;
            else if (lvl && s == 3'd3) target = 3'd4;
         end
         default: target = NO_FIT;
      endcase
      return target;
   endfunction

   function automatic bridge_cmd_type step_bridge(input opcode_type op, input logic lvl);
      bridge_cmd_type      cmd;
      logic [SECTOR_W-1:0] target;
      int unsigned         period;
      int unsigned         product;
      cmd = '0;
      cmd.sector = sector_q;
      if (speed_q == '0) begin
         prescale_q = '0;
         step_q     = '0;
         delay_q    = '0;
      end else begin
         cmd.drive_on = 1'b1;
         product      = 32'(pwm_q) * 32'(speed_q);
         cmd.duty     = DUTY_W'(product / DUTY_DIVISOR);
         if (mode_q == 1'b0) begin
            if (op == OP_TICK) begin
               period = STEP_BASE / speed_q;
               if (int'(prescale_q) + 1 >= STEP_PRESCALE) begin
                  prescale_q = '0;
                  // >= so a period lowered under the count expires right away
                  if (int'(step_q) + 1 >= int'(period)) begin
                     step_q        = '0;
                     cmd.commutate = 1'b1;
                     sector_q      = (sector_q == SECTOR_LAST) ? '0 : sector_q + 1'b1;
                  end else begin
                     step_q = step_q + 1'b1;
                  end
               end else begin
                  prescale_q = prescale_q + 1'b1;
               end
            end
         end else if (op == OP_TICK) begin
            period = DELAY_BASE / speed_q;
            if (int'(delay_q) + 1 >= int'(period)) begin
               delay_q       = '0;
               cmd.commutate = 1'b1;
            end else begin
               delay_q = delay_q + 1'b1;
            end
         end else begin
            target = fitting_sector(op, lvl, sector_q);
            if (target != NO_FIT) begin
               sector_q = target;
               delay_q  = '0;
            end
            cmd.sector = sector_q;
         end
      end
      return cmd;
   endfunction

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      bridge_cmd_type want_cmd;
      bridge_cmd_type got_cmd;
      if (reset) begin
         mode_q     = 1'b0;
         speed_q    = '0;
         pwm_q      = '0;
         sector_q   = '0;
         prescale_q = '0;
         step_q     = '0;
         delay_q    = '0;
         expected_cmds.delete();
         fail_count        = 0;
         checked_count     = 0;
         commutation_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_MODE_SEL:   mode_q  = csr_wdata[0];
               CSR_SPEED:      speed_q = csr_wdata[SPEED_W-1:0];
               CSR_PWM_PERIOD: pwm_q   = csr_wdata[PWM_W-1:0];
               default:        ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_cmds.push_back(step_bridge(opcode_type'(req_tdata[OPCODE_W-1:0]),
                                                req_tdata[OPCODE_W]));
         if (rsp_tvalid && rsp_tready) begin
            got_cmd = rsp_tdata[$bits(bridge_cmd_type)-1:0];
            if (expected_cmds.size() == 0) begin
               $display("%0t: result beat with none expected, expected nothing, got %h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               want_cmd = expected_cmds.pop_front();
               compare_field("sector_out", want_cmd.sector, got_cmd.sector);
               compare_field("commutate", want_cmd.commutate, got_cmd.commutate);
               compare_field("drive_on", want_cmd.drive_on, got_cmd.drive_on);
               compare_field("duty", want_cmd.duty, got_cmd.duty);
               checked_count++;
               if (want_cmd.commutate) commutation_count++;
            end
         end
      end
      pending <= expected_cmds.size();
   end

endmodule

[test/bldc_six_step_commutator_test.sv]
module bldc_six_step_commutator_test;
   import bssc_pkg::*;

   localparam int ITEM_TARGET  = 1250;
   localparam int QUIET_ITEMS  = 80;
   localparam int IDLE_LIMIT   = 3000;
   localparam int SETTLE_TICKS = 10;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int pending, fail_count, checked_count, commutation_count;
   int beats_sent = 0, reg_writes = 0, idle_cycles = 0;
   int gap_odds = 3, stall_odds = 4, stall_left = 0;   // odds 0: no idling
   int tick_run = 0, tick_run_max = 100, edge_ptr = 0, cur_mode = 0;

   // zero crossings in rotation order, starting with the one that leaves sector 0
   opcode_type edge_op  [6] = '{OP_EDGE_C, OP_EDGE_B, OP_EDGE_A,
                                OP_EDGE_C, OP_EDGE_B, OP_EDGE_A};
   logic       edge_lvl [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

   always #10 clock = ~clock;

   bldc_six_step_commutator uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   bldc_six_step_commutator_checker bridge_monitor (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .pending           (pending),
      .fail_count        (fail_count),
      .checked_count     (checked_count),
      .commutation_count (commutation_count)
   );

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
         stall_left <= $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                  $time, IDLE_LIMIT, pending);
         $display("** bldc_six_step_commutator: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_beat(input opcode_type op, input logic lvl);
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tdata  <= {{(REQ_DATA_W - OPCODE_W - 1){1'b0}}, lvl, op};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
      if ($urandom_range(0, 249) == 0) drain_results();
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input int unsigned value);
      // a previous write may still be recomputing the periods
      while (!req_tready) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      reg_writes++;
   endtask

   task automatic send_next_edge();
      send_beat(edge_op[edge_ptr], edge_lvl[edge_ptr]);
      edge_ptr = (edge_ptr + 1) % 6;
   endtask

   task automatic feed_open_loop(input int count);
      repeat (count) begin
         if ($urandom_range(0, 19) == 0)
            send_beat(opcode_type'($urandom_range(1, 3)), 1'($urandom_range(0, 1)));
         else
            send_beat(OP_TICK, 1'($urandom_range(0, 1)));
      end
   endtask

   // runs of ticks between zero crossings; crossings mostly in rotation order
   task automatic feed_sensorless(input int count);
      int pick;
      repeat (count) begin
         if (tick_run > 0) begin
            tick_run--;
            send_beat(OP_TICK, 1'($urandom_range(0, 1)));
         end else begin
            pick = $urandom_range(0, 9);
            if (pick == 7) begin
               send_beat(opcode_type'($urandom_range(1, 3)), 1'($urandom_range(0, 1)));
            end else begin
               // a missed crossing stalls the rotation until the order comes round
               if (pick > 7) edge_ptr = (edge_ptr + 1) % 6;
               send_next_edge();
            end
            tick_run = $urandom_range(0, tick_run_max);
         end
      end
   endtask

   initial begin : stimulus
      int speed;
      int pwm;
      int run;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // drive off: nothing moves, sector held
      send_beat(OP_TICK, 1'b0);
      send_beat(OP_TICK, 1'b1);
      send_beat(OP_EDGE_C, 1'b0);
      drain_results();
      write_reg(CSR_MODE_SEL, 1);
      send_beat(OP_EDGE_C, 1'b0);
      drain_results();
      write_reg(CSR_SPEED, 255);
      write_reg(CSR_PWM_PERIOD, 32767);
      // full turn with one misfit crossing in it
      send_beat(OP_EDGE_C, 1'b0);
      send_beat(OP_EDGE_A, 1'b1);
      send_beat(OP_EDGE_B, 1'b1);
      send_beat(OP_EDGE_A, 1'b0);
      send_beat(OP_EDGE_C, 1'b1);
      send_beat(OP_EDGE_B, 1'b0);
      send_beat(OP_EDGE_A, 1'b1);
      send_beat(OP_TICK, 1'b1);
      drain_results();
      write_reg(CSR_MODE_SEL, 0);
      write_reg(CSR_SPEED, 1);
      write_reg(CSR_PWM_PERIOD, 0);
      send_beat(OP_TICK, 1'b0);
      send_beat(OP_EDGE_B, 1'b1);
      send_beat(OP_TICK, 1'b1);
      drain_results();
      write_reg(CSR_SPEED, 255);
      write_reg(CSR_PWM_PERIOD, 1);
      send_beat(OP_TICK, 1'b0);
      drain_results();

      // build the step count past the full-speed period, below the half-speed one
      write_reg(CSR_SPEED, 128);
      write_reg(CSR_PWM_PERIOD, $urandom_range(0, 32767));
      feed_open_loop(480);
      drain_results();
      // turn the rotor to sector 5, then let the delay count build
      write_reg(CSR_MODE_SEL, 1);
      edge_ptr = 0;
      repeat (17) send_next_edge();
      repeat (200) send_beat(OP_TICK, 1'($urandom_range(0, 1)));
      drain_results();
      // shorter step period: expires on the next count and wraps 5 to 0
      write_reg(CSR_MODE_SEL, 0);
      write_reg(CSR_SPEED, 255);
      feed_open_loop(40);
      drain_results();
      // held delay count already past the new delay period
      write_reg(CSR_MODE_SEL, 1);
      cur_mode     = 1;
      tick_run     = 0;
      tick_run_max = 200;
      feed_sensorless(250);
      drain_results();

      while (beats_sent < ITEM_TARGET - QUIET_ITEMS) begin
         gap_odds   = $urandom_range(0, 2) * 3;
         stall_odds = $urandom_range(0, 2) * 3;
         case ($urandom_range(0, 7))
            0:       speed = 0;
            1:       speed = 1;
            2, 3:    speed = 255;
            default: speed = $urandom_range(1, 255);
         endcase
         case ($urandom_range(0, 3))
            0:       pwm = 0;
            1:       pwm = 32767;
            default: pwm = $urandom_range(0, 32767);
         endcase
         if ($urandom_range(0, 2) != 0) begin
            cur_mode = $urandom_range(0, 1);
            write_reg(CSR_MODE_SEL, cur_mode);
         end
         if ($urandom_range(0, 3) != 0) write_reg(CSR_SPEED, speed);
         if ($urandom_range(0, 2) != 0) write_reg(CSR_PWM_PERIOD, pwm);
         run          = $urandom_range(40, 160);
         if (run > ITEM_TARGET - QUIET_ITEMS - beats_sent)
            run = ITEM_TARGET - QUIET_ITEMS - beats_sent;
         tick_run_max = $urandom_range(20, 250);
         if (cur_mode == 0) feed_open_loop(run);
         else feed_sensorless(run);
         drain_results();
      end

      gap_odds   = 0;
      stall_odds = 0;
      write_reg(CSR_MODE_SEL, 1);
      write_reg(CSR_SPEED, 255);
      write_reg(CSR_PWM_PERIOD, $urandom_range(0, 32767));
      tick_run_max = 150;
      feed_sensorless(QUIET_ITEMS);
      drain_results();

      $display("Sent %0d request beats and checked %0d results, %0d of them commutations,",
               beats_sent, checked_count, commutation_count);
      $display("over %0d register writes: drive off, open-loop and zero-crossing modes.",
               reg_writes);
      if (fail_count == 0)
         $display("** bldc_six_step_commutator: PASSED **");
      else
         $display("** bldc_six_step_commutator: FAILED **");
      $finish;
   end

endmodule

[sim.f]
rtl/core/bssc_pkg.sv
rtl/core/bssc_ctrl.sv
rtl/core/bssc_dp.sv
rtl/core/bldc_six_step_commutator.sv
test/bldc_six_step_commutator_checker.sv
test/bldc_six_step_commutator_test.sv
